// ===== design/lsu_pkg.sv =====
// Shared types, operand codes and register-file helpers for the load/store unit.
// No dependencies; every other design file imports this package.
`default_nettype none
package lsu_pkg;

  // Byte memory geometry: two banks of even and odd bytes.
  localparam int MEM_ADDR_BITS = 16;
  localparam int BANK_AW       = MEM_ADDR_BITS - 1;
  localparam int BANK_DEPTH    = 2 ** BANK_AW;

  localparam logic [15:0] HIGH_PAGE = 16'hff00;

  localparam logic CMD_LD  = 1'b0;
  localparam logic CMD_LDH = 1'b1;

  localparam logic [4:0] OPD_A     = 5'd0;
  localparam logic [4:0] OPD_B     = 5'd1;
  localparam logic [4:0] OPD_C     = 5'd2;
  localparam logic [4:0] OPD_D     = 5'd3;
  localparam logic [4:0] OPD_E     = 5'd4;
  localparam logic [4:0] OPD_H     = 5'd5;
  localparam logic [4:0] OPD_L     = 5'd6;
  localparam logic [4:0] OPD_IBC   = 5'd7;
  localparam logic [4:0] OPD_IDE   = 5'd8;
  localparam logic [4:0] OPD_IHL   = 5'd9;
  localparam logic [4:0] OPD_IHLI  = 5'd10;
  localparam logic [4:0] OPD_IHLD  = 5'd11;
  localparam logic [4:0] OPD_IMM8  = 5'd12;
  localparam logic [4:0] OPD_IA16  = 5'd13;
  localparam logic [4:0] OPD_BC    = 5'd14;
  localparam logic [4:0] OPD_DE    = 5'd15;
  localparam logic [4:0] OPD_HL    = 5'd16;
  localparam logic [4:0] OPD_SP    = 5'd17;
  localparam logic [4:0] OPD_IMM16 = 5'd18;
  localparam logic [4:0] OPD_HC    = 5'd19;
  localparam logic [4:0] OPD_HIMM  = 5'd20;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [15:0] sp;
    logic [3:0]  flags;
  } regs_t;

  typedef struct packed {
    regs_t      regs;
    logic [1:0] adv;
    logic       illegal;
  } result_t;

  typedef struct packed {
    regs_t      regs_nxt;
    logic       ok;
    logic [1:0] adv;
    logic       load;
    logic [2:0] load_dst;
  } exec_t;

  // One read, or a write of one or two consecutive bytes.
  typedef struct packed {
    logic        rd_en;
    logic [15:0] rd_addr;
    logic        wr_en;
    logic        wr2_en;
    logic [15:0] wr_addr;
    logic [7:0]  wr_data;
    logic [7:0]  wr2_data;
  } mem_req_t;

  function automatic logic [7:0] r8_get(input regs_t r, input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      OPD_B[2:0]: v = r.b;
      OPD_C[2:0]: v = r.c;
      OPD_D[2:0]: v = r.d;
      OPD_E[2:0]: v = r.e;
      OPD_H[2:0]: v = r.h;
      OPD_L[2:0]: v = r.l;
      default:    v = r.a;
    endcase
    return v;
  endfunction

  function automatic regs_t r8_set(input regs_t r, input logic [2:0] idx,
                                   input logic [7:0] v);
    regs_t o;
    o = r;
    unique case (idx)
      OPD_B[2:0]: o.b = v;
      OPD_C[2:0]: o.c = v;
      OPD_D[2:0]: o.d = v;
      OPD_E[2:0]: o.e = v;
      OPD_H[2:0]: o.h = v;
      OPD_L[2:0]: o.l = v;
      default:    o.a = v;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== design/lsu_ifs.sv =====
// Valid/ready channel interfaces for the instruction input and the result output.
// Depends on lsu_pkg for nothing but house consistency of widths.
`default_nettype none
interface lsu_in_if
  import lsu_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [4:0] dst_operand;
  logic [4:0] src_operand;
  logic [7:0] imm_low;
  logic [7:0] imm_high;

  modport source (output valid, cmd, dst_operand, src_operand, imm_low, imm_high,
                  input ready);
  modport sink   (input valid, cmd, dst_operand, src_operand, imm_low, imm_high,
                  output ready);
endinterface

interface lsu_out_if
  import lsu_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic [7:0]  out_a;
  logic [7:0]  out_b;
  logic [7:0]  out_c;
  logic [7:0]  out_d;
  logic [7:0]  out_e;
  logic [7:0]  out_h;
  logic [7:0]  out_l;
  logic [15:0] out_sp;
  logic [3:0]  out_flags;
  logic [1:0]  pc_advance;
  logic        illegal;

  modport source (output valid, out_a, out_b, out_c, out_d, out_e, out_h, out_l,
                  out_sp, out_flags, pc_advance, illegal, input ready);
  modport sink   (input valid, out_a, out_b, out_c, out_d, out_e, out_h, out_l,
                  out_sp, out_flags, pc_advance, illegal, output ready);
endinterface
`default_nettype wire

// ===== design/lsu_decode.sv =====
// Instruction decode and execute: next register state and the memory request.
// Depends on lsu_pkg.
`default_nettype none
module lsu_decode
  import lsu_pkg::*;
(
  input  wire logic       cmd,
  input  wire logic [4:0] dst_operand,
  input  wire logic [4:0] src_operand,
  input  wire logic [7:0] imm_low,
  input  wire logic [7:0] imm_high,
  input  wire regs_t      regs,
  output exec_t           ex,
  output mem_req_t        req
);

  logic [15:0] hl, bc, de, imm16, hl_inc, hl_dec, sp_ofs;
  logic [4:0]  nib_sum;
  logic [8:0]  byte_sum;

  assign hl       = {regs.h, regs.l};
  assign bc       = {regs.b, regs.c};
  assign de       = {regs.d, regs.e};
  assign imm16    = {imm_high, imm_low};
  assign hl_inc   = hl + 16'd1;
  assign hl_dec   = hl - 16'd1;
  assign sp_ofs   = regs.sp + {{8{imm_low[7]}}, imm_low};
  assign nib_sum  = {1'b0, regs.sp[3:0]} + {1'b0, imm_low[3:0]};
  assign byte_sum = {1'b0, regs.sp[7:0]} + {1'b0, imm_low};

  always_comb begin
    ex          = '0;
    ex.regs_nxt = regs;
    ex.load_dst = dst_operand[2:0];
    req         = '0;
    req.wr_data = regs.a;

    if (cmd == CMD_LD) begin
      if (dst_operand <= OPD_L) begin
        if (src_operand <= OPD_L) begin
          ex.regs_nxt = r8_set(regs, dst_operand[2:0], r8_get(regs, src_operand[2:0]));
          ex.ok       = 1'b1;
        end else if (src_operand == OPD_IHL) begin
          ex.load = 1'b1;  req.rd_en = 1'b1;  req.rd_addr = hl;  ex.ok = 1'b1;
        end else if (src_operand == OPD_IMM8) begin
          ex.regs_nxt = r8_set(regs, dst_operand[2:0], imm_low);
          ex.adv      = 2'd1;
          ex.ok       = 1'b1;
        end else if (dst_operand == OPD_A) begin
          if (src_operand == OPD_IBC) begin
            ex.load = 1'b1;  req.rd_en = 1'b1;  req.rd_addr = bc;  ex.ok = 1'b1;
          end else if (src_operand == OPD_IDE) begin
            ex.load = 1'b1;  req.rd_en = 1'b1;  req.rd_addr = de;  ex.ok = 1'b1;
          end else if (src_operand == OPD_IHLI || src_operand == OPD_IHLD) begin
            ex.load = 1'b1;  req.rd_en = 1'b1;  req.rd_addr = hl;  ex.ok = 1'b1;
            {ex.regs_nxt.h, ex.regs_nxt.l} = (src_operand == OPD_IHLI) ? hl_inc : hl_dec;
          end else if (src_operand == OPD_IA16) begin
            ex.load = 1'b1;  req.rd_en = 1'b1;  req.rd_addr = imm16;
            ex.adv  = 2'd2;  ex.ok = 1'b1;
          end
        end
      end else begin
        unique case (dst_operand)
          OPD_IBC, OPD_IDE: begin
            if (src_operand == OPD_A) begin
              req.wr_en   = 1'b1;
              req.wr_addr = (dst_operand == OPD_IBC) ? bc : de;
              ex.ok       = 1'b1;
            end
          end
          OPD_IHL: begin
            if (src_operand <= OPD_L) begin
              req.wr_en   = 1'b1;
              req.wr_addr = hl;
              req.wr_data = r8_get(regs, src_operand[2:0]);
              ex.ok       = 1'b1;
            end else if (src_operand == OPD_IMM8) begin
              req.wr_en   = 1'b1;
              req.wr_addr = hl;
              req.wr_data = imm_low;
              ex.adv      = 2'd1;
              ex.ok       = 1'b1;
            end
          end
          OPD_IHLI, OPD_IHLD: begin
            if (src_operand == OPD_A) begin
              req.wr_en   = 1'b1;
              req.wr_addr = hl;
              {ex.regs_nxt.h, ex.regs_nxt.l} = (dst_operand == OPD_IHLI) ? hl_inc : hl_dec;
              ex.ok       = 1'b1;
            end
          end
          OPD_IA16: begin
            if (src_operand == OPD_A) begin
              req.wr_en   = 1'b1;
              req.wr_addr = imm16;
              ex.adv      = 2'd2;
              ex.ok       = 1'b1;
            end else if (src_operand == OPD_SP) begin
              // Little-endian: low byte at the address, high byte just above it.
              req.wr_en    = 1'b1;
              req.wr2_en   = 1'b1;
              req.wr_addr  = imm16;
              req.wr_data  = regs.sp[7:0];
              req.wr2_data = regs.sp[15:8];
              ex.adv       = 2'd2;
              ex.ok        = 1'b1;
            end
          end
          OPD_BC: begin
            if (src_operand == OPD_IMM16) begin
              ex.regs_nxt.b = imm_high;  ex.regs_nxt.c = imm_low;
              ex.adv = 2'd2;  ex.ok = 1'b1;
            end
          end
          OPD_DE: begin
            if (src_operand == OPD_IMM16) begin
              ex.regs_nxt.d = imm_high;  ex.regs_nxt.e = imm_low;
              ex.adv = 2'd2;  ex.ok = 1'b1;
            end
          end
          OPD_HL: begin
            if (src_operand == OPD_IMM16) begin
              ex.regs_nxt.h = imm_high;  ex.regs_nxt.l = imm_low;
              ex.adv = 2'd2;  ex.ok = 1'b1;
            end else if (src_operand == OPD_IMM8) begin
              // Half carry and carry come from the unsigned low nibble and low byte.
              {ex.regs_nxt.h, ex.regs_nxt.l} = sp_ofs;
              ex.regs_nxt.flags = {2'b00, nib_sum[4], byte_sum[8]};
              ex.adv = 2'd1;  ex.ok = 1'b1;
            end
          end
          OPD_SP: begin
            if (src_operand == OPD_IMM16) begin
              ex.regs_nxt.sp = imm16;  ex.adv = 2'd2;  ex.ok = 1'b1;
            end else if (src_operand == OPD_HL) begin
              ex.regs_nxt.sp = hl;  ex.ok = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end else begin
      if (dst_operand == OPD_A && src_operand == OPD_HC) begin
        ex.load = 1'b1;  req.rd_en = 1'b1;
        req.rd_addr = HIGH_PAGE | {8'h00, regs.c};
        ex.ok = 1'b1;
      end else if (dst_operand == OPD_A && src_operand == OPD_HIMM) begin
        ex.load = 1'b1;  req.rd_en = 1'b1;
        req.rd_addr = HIGH_PAGE | {8'h00, imm_low};
        ex.adv = 2'd1;  ex.ok = 1'b1;
      end else if (dst_operand == OPD_HC && src_operand == OPD_A) begin
        req.wr_en = 1'b1;  req.wr_addr = HIGH_PAGE | {8'h00, regs.c};  ex.ok = 1'b1;
      end else if (dst_operand == OPD_HIMM && src_operand == OPD_A) begin
        req.wr_en = 1'b1;  req.wr_addr = HIGH_PAGE | {8'h00, imm_low};
        ex.adv = 2'd1;  ex.ok = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/lsu_mem.sv =====
// Byte memory split into an even and an odd bank, so a two-byte store is one write each.
// One read per cycle with registered data. Depends on lsu_pkg.
`default_nettype none
module lsu_mem
  import lsu_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output logic [7:0]    rd_data
);

  logic [7:0] even_mem [BANK_DEPTH];
  logic [7:0] odd_mem  [BANK_DEPTH];

  logic [7:0]         even_rd_r, odd_rd_r;
  logic               rd_odd_r;
  logic [15:0]        wr_addr_hi;
  logic [BANK_AW-1:0] even_waddr, odd_waddr, rd_idx;
  logic               even_we, odd_we;
  logic [7:0]         even_wdata, odd_wdata;

  assign wr_addr_hi = req.wr_addr + 16'd1;
  assign rd_idx     = req.rd_addr[MEM_ADDR_BITS-1:1];

  // The first byte lands in the bank its address picks; the second byte in the other.
  always_comb begin
    if (req.wr_addr[0]) begin
      odd_waddr  = req.wr_addr[MEM_ADDR_BITS-1:1];
      odd_wdata  = req.wr_data;
      odd_we     = req.wr_en;
      even_waddr = wr_addr_hi[MEM_ADDR_BITS-1:1];
      even_wdata = req.wr2_data;
      even_we    = req.wr2_en;
    end else begin
      even_waddr = req.wr_addr[MEM_ADDR_BITS-1:1];
      even_wdata = req.wr_data;
      even_we    = req.wr_en;
      odd_waddr  = wr_addr_hi[MEM_ADDR_BITS-1:1];
      odd_wdata  = req.wr2_data;
      odd_we     = req.wr2_en;
    end
  end

  always_ff @(posedge clk) begin
    if (even_we) even_mem[even_waddr] <= even_wdata;
    if (odd_we)  odd_mem[odd_waddr]   <= odd_wdata;
    if (req.rd_en) begin
      even_rd_r <= even_mem[rd_idx];
      odd_rd_r  <= odd_mem[rd_idx];
      rd_odd_r  <= req.rd_addr[0];
    end
  end

  assign rd_data = rd_odd_r ? odd_rd_r : even_rd_r;

endmodule
`default_nettype wire

// ===== design/lsu_outq.sv =====
// Two-entry result buffer: a head register shown on the output and a skid entry behind it.
// Depends on lsu_pkg.
`default_nettype none
module lsu_outq
  import lsu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  input  wire logic    pop_ready,
  output logic         head_valid,
  output result_t      head_data,
  output logic         room
);

  logic    head_v_r, head_v_nxt, skid_v_r, skid_v_nxt, pop;
  result_t head_r, head_nxt, skid_r, skid_nxt;

  assign pop  = head_v_r && pop_ready;
  assign room = !(head_v_r && skid_v_r) || pop;

  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop) begin
      head_v_nxt = skid_v_r;
      head_nxt   = skid_r;
      skid_v_nxt = 1'b0;
    end
    if (push) begin
      if (!head_v_nxt) begin
        head_v_nxt = 1'b1;
        head_nxt   = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign head_valid = head_v_r;
  assign head_data  = head_r;

endmodule
`default_nettype wire

// ===== design/cpu_load_store_unit_core.sv =====
// Load/store unit for the 8-bit LD and LDH instruction families: top level.
// Instantiates lsu_decode, lsu_mem and lsu_outq; depends on lsu_pkg and lsu_ifs.
//
// Usage: each word on in_ch is one decoded instruction (family, destination and
// source operand codes, the two immediate bytes). Each accepted word yields exactly
// one word on out_ch carrying A..L, SP and the flags after the instruction, the
// program counter advance and an illegal-form marker. Illegal forms change nothing.
// Both channels use valid/ready; a word moves on a clock edge with both high.
//
// Order: register, immediate and store forms enter the result buffer at acceptance
// and report from its head register; a memory load waits in the byte memory's registered
// read data, marked by the pending-load flag, before it enters the buffer.
// Throughput: one word per cycle for everything except loads, while the result buffer
// has room; a load holds in_ch.ready low for one cycle while its data is written back.
// Stores are complete at acceptance, so a load right after a store sees the new byte.
//
// Reset (rst_n low at a clock edge) clears A..L, SP, the flags, the pending-load flag
// and the buffer's valid bits. The byte memory is not cleared; bytes never written
// read as garbage. A stalled receiver is absorbed by a two-entry result buffer; the
// unit keeps taking words until that buffer is full and then drops in_ch.ready.
`default_nettype none
module cpu_load_store_unit_core
  import lsu_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst_n,
  lsu_in_if.sink     in_ch,
  lsu_out_if.source  out_ch
);

  regs_t      regs_r, regs_nxt;
  logic       pend_r;
  logic [2:0] pend_dst_r;
  logic [1:0] pend_adv_r;

  exec_t      ex;
  mem_req_t   req, req_g;
  logic [7:0] rd_data;
  logic       fire, room, push;
  result_t    push_data, head_data;
  regs_t      load_regs;

  lsu_decode u_decode (
    .cmd         (in_ch.cmd),
    .dst_operand (in_ch.dst_operand),
    .src_operand (in_ch.src_operand),
    .imm_low     (in_ch.imm_low),
    .imm_high    (in_ch.imm_high),
    .regs        (regs_r),
    .ex          (ex),
    .req         (req)
  );

  // A pending load owns the register file for one cycle, so no word is taken then.
  assign in_ch.ready = !pend_r && room;
  assign fire        = in_ch.valid && in_ch.ready;

  always_comb begin
    req_g        = req;
    req_g.rd_en  = req.rd_en && fire;
    req_g.wr_en  = req.wr_en && fire;
    req_g.wr2_en = req.wr2_en && fire;
  end

  lsu_mem u_mem (
    .clk     (clk),
    .req     (req_g),
    .rd_data (rd_data)
  );

  // The load result is the register file with the destination replaced by memory data.
  assign load_regs = r8_set(regs_r, pend_dst_r, rd_data);

  always_comb begin
    regs_nxt  = regs_r;
    push      = 1'b0;
    push_data = '0;
    if (pend_r) begin
      regs_nxt          = load_regs;
      push              = 1'b1;
      push_data.regs    = load_regs;
      push_data.adv     = pend_adv_r;
      push_data.illegal = 1'b0;
    end else if (fire) begin
      regs_nxt = ex.regs_nxt;
      if (!ex.load) begin
        push              = 1'b1;
        push_data.regs    = ex.regs_nxt;
        push_data.adv     = ex.ok ? ex.adv : 2'd0;
        push_data.illegal = !ex.ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
      pend_r <= 1'b0;
    end else begin
      regs_r <= regs_nxt;
      pend_r <= fire && ex.load;
    end
    pend_dst_r <= ex.load_dst;
    pend_adv_r <= ex.adv;
  end

  lsu_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop_ready  (out_ch.ready),
    .head_valid (out_ch.valid),
    .head_data  (head_data),
    .room       (room)
  );

  assign out_ch.out_a      = head_data.regs.a;
  assign out_ch.out_b      = head_data.regs.b;
  assign out_ch.out_c      = head_data.regs.c;
  assign out_ch.out_d      = head_data.regs.d;
  assign out_ch.out_e      = head_data.regs.e;
  assign out_ch.out_h      = head_data.regs.h;
  assign out_ch.out_l      = head_data.regs.l;
  assign out_ch.out_sp     = head_data.regs.sp;
  assign out_ch.out_flags  = head_data.regs.flags;
  assign out_ch.pc_advance = head_data.adv;
  assign out_ch.illegal    = head_data.illegal;

endmodule
`default_nettype wire

// ===== design/lsu_checker.sv =====
// Port-level checks for the load/store unit, bound onto the top level.
// Depends on lsu_pkg and the top level cpu_load_store_unit_core.
`default_nettype none
module lsu_checker
  import lsu_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_sp,
  input wire logic [1:0]  out_pc_advance,
  input wire logic        out_illegal
);

  // A word shown on the output stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sp) && $stable(out_pc_advance)
                                && $stable(out_illegal))
    else $error("result word changed while stalled");

  // An illegal form never skips immediate bytes.
  a_illegal_adv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal |-> out_pc_advance == 2'd0)
    else $error("illegal form reports a program counter advance");

  // With an empty output, an accepted word shows up next cycle unless a load holds input.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> out_valid || !in_ready)
    else $error("result word missing after acceptance");

endmodule

bind cpu_load_store_unit_core lsu_checker u_lsu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_sp         (out_ch.out_sp),
  .out_pc_advance (out_ch.pc_advance),
  .out_illegal    (out_ch.illegal)
);
`default_nettype wire
